// ===== design/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block except hcbp_ram.
package hcbp_pkg;

	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int SYM_W  = 7;
	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_END    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_FLUSH
	} state_t;

	// shifter -> control
	typedef struct packed {
		logic             valid;
		logic             data;
		logic [LEN_W-1:0] rem;   // bits left after the current one
	} shf_status_t;

	// control -> packer
	typedef struct packed {
		logic valid;
		logic data;
		logic last;
		logic stream_end;
	} pk_bit_t;

	// packer -> control
	typedef struct packed {
		logic ready;
		logic empty;      // no bits held
		logic last_slot;  // next bit completes a byte
	} pk_status_t;

endpackage

// ===== design/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package needed.
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/hcbp_shifter.sv =====
// Code word shift register: left-aligns a code on load, then gives one bit
// per cycle while take is high, most significant first. Depends on hcbp_pkg.
module hcbp_shifter
	import hcbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [CODE_W-1:0] load_code,
	input  logic [LEN_W-1:0]  load_len,
	input  logic              take,
	output shf_status_t       status
);

	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  shamt;

	// length never exceeds CODE_W, so the amount fits
	assign shamt = LEN_W'(CODE_W) - load_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_len;
		end else if (take && (cnt_q != '0)) begin
			cnt_q <= cnt_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= load_code << shamt;
		end else if (take) begin
			code_q <= {code_q[CODE_W-2:0], 1'b0};
		end
	end

	always_comb begin
		status.valid = (cnt_q != '0);
		status.data  = code_q[CODE_W-1];
		status.rem   = cnt_q - LEN_W'(1);
	end

endmodule

// ===== design/hcbp_packer.sv =====
// Byte accumulator: takes one bit a cycle, stalling a word's eighth bit while the
// output register is held, and emits a word into it once eight bits are in. Depends on hcbp_pkg.
module hcbp_packer
	import hcbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  pk_bit_t           bit_in,
	output pk_status_t        status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              out_stream_end
);

	logic [BYTE_W-2:0] acc_q;
	logic [2:0]        pend_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_se_q;
	logic              completes;
	logic              out_free;
	logic              take;

	assign completes = (pend_q == 3'd7);
	assign out_free  = !out_valid_q || out_ready;
	assign take      = bit_in.valid && (!completes || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q  <= {acc_q[BYTE_W-3:0], bit_in.data};
				pend_q <= pend_q + 3'd1;
			end
			if (take && completes) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && completes) begin
			out_byte_q <= {acc_q, bit_in.data};
			out_last_q <= bit_in.last;
			out_se_q   <= bit_in.stream_end;
		end
	end

	always_comb begin
		status.ready     = !completes || out_free;
		status.empty     = (pend_q == 3'd0);
		status.last_slot = completes;
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign out_last       = out_last_q;
	assign out_stream_end = out_se_q;

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Huffman code bit packer: code table, bit-serial shifter, byte packer.
// Load: writes an in-range table entry and stays idle. Encode: reads the table,
// loads the code into the shifter, then gives one bit per cycle to the packer,
// stalling while the output register is held. End: as encode of symbol 0, plus zero fill for a partial word.
// Async active-low reset clears control, bit count and output valid; the
// code table is not cleared and must be loaded before use.
module huffman_code_bit_packer
	import hcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // symbol[6:0], entry_length[12:7], entry_code[44:13], zero
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // stream_end[0]
);

	localparam int AW      = $clog2(SYMBOL_COUNT);
	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int RAM_W   = CODE_W + LEN_W;

	state_t state_q, state_d;
	logic   is_end_q;

	op_t               op;
	logic [SYM_W-1:0]  symbol;
	logic [LEN_W-1:0]  entry_length;
	logic [CODE_W-1:0] entry_code;
	logic [8:0]        sym_ext;
	logic [AW-1:0]     sym_addr;
	logic              in_range;
	logic              accept;
	logic [LEN_W-1:0]  len_sat;

	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [RAM_W-1:0]  rd_data;

	logic              shf_load;
	logic              shf_take;
	shf_status_t       shf_st;
	pk_bit_t           pk_bit;
	pk_status_t        pk_st;

	assign op           = op_t'(s_tuser);
	assign symbol       = s_tdata[6:0];
	assign entry_length = s_tdata[12:7];
	assign entry_code   = s_tdata[44:13];
	assign sym_ext      = {2'b00, symbol};
	assign sym_addr     = sym_ext[AW-1:0];
	assign in_range     = (sym_ext < 9'(SYMBOL_COUNT));
	assign accept       = s_tvalid && s_tready;
	assign len_sat      = (entry_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : entry_length;

	hcbp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(sym_addr),
		.wr_data({len_sat, entry_code}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	hcbp_shifter u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (shf_load),
		.load_code(rd_data[CODE_W-1:0]),
		.load_len (rd_data[RAM_W-1:CODE_W]),
		.take     (shf_take),
		.status   (shf_st)
	);

	hcbp_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.bit_in        (pk_bit),
		.status        (pk_st),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (m_tdata),
		.out_last      (m_tlast),
		.out_stream_end(m_tuser[0])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			is_end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				is_end_q <= (op == OP_END);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_ENCODE: state_d = in_range ? ST_READ : ST_IDLE;
						OP_END:    state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (!shf_st.valid) begin
					state_d = (is_end_q && !pk_st.empty) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (pk_st.ready && pk_st.last_slot) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready          = 1'b0;
		wr_en             = 1'b0;
		rd_en             = 1'b0;
		rd_addr           = sym_addr;
		shf_load          = 1'b0;
		shf_take          = 1'b0;
		pk_bit.valid      = 1'b0;
		pk_bit.data       = shf_st.data;
		// a word is last once fewer than eight code bits remain; on end it
		// is last only if nothing is left for the zero fill
		pk_bit.last       = is_end_q ? (shf_st.rem == '0) : (shf_st.rem < LEN_W'(BYTE_W));
		pk_bit.stream_end = is_end_q && (shf_st.rem == '0);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				wr_en    = accept && (op == OP_LOAD) && in_range;
				rd_en    = accept && ((op == OP_ENCODE) || (op == OP_END));
				rd_addr  = (op == OP_END) ? '0 : sym_addr;
			end
			ST_READ: begin
				shf_load = 1'b1;
			end
			ST_SHIFT: begin
				pk_bit.valid = shf_st.valid;
				shf_take     = shf_st.valid && pk_st.ready;
			end
			ST_FLUSH: begin
				pk_bit.valid      = 1'b1;
				pk_bit.data       = 1'b0;
				pk_bit.last       = 1'b1;
				pk_bit.stream_end = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shf_st.valid |-> (shf_st.rem < LEN_W'(LEN_CAP)))
		else $error("shifter holds more bits than the length cap");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> !pk_st.empty)
		else $error("zero fill with no bits held");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("stream end word without last");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_LOAD)) |=> (state_q == ST_IDLE))
		else $error("table load left idle");

endmodule
